@@ sv/ascii_command_decoder_macros.svh @@
// Assertion macros used by the command decoder top level.
`ifndef ASCII_COMMAND_DECODER_MACROS_SVH
`define ASCII_COMMAND_DECODER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ACD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("command decoder check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ACD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("command decoder check failed");

`endif

@@ sv/acd_pkg.sv @@
// Types, character codes and decimal helpers for the ASCII command decoder.
package acd_pkg;

	typedef enum logic [3:0] {
		CMD_NONE      = 4'd0,
		CMD_STOP      = 4'd1,
		CMD_START     = 4'd2,
		CMD_INPUT     = 4'd3,
		CMD_RATE      = 4'd4,
		CMD_TEST1     = 4'd5,
		CMD_TEST2     = 4'd6,
		CMD_GEN_START = 4'd7,
		CMD_GEN_STOP  = 4'd8
	} cmd_t;

	typedef enum logic [1:0] {
		WAVE_SINE   = 2'd0,
		WAVE_RAMP   = 2'd1,
		WAVE_SQUARE = 2'd2
	} wave_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_Q     = 8'h51;

	localparam logic [7:0]  CHANNEL_RESET = 8'd2;
	localparam logic [15:0] RATE_RESET    = 16'd2500;
	localparam logic [15:0] DIVIDER_RESET = 16'd1;

	localparam int WORD_W = 64;
	localparam int OUT_W  = 56;

	typedef struct packed {
		cmd_t        found;
		logic [7:0]  channel;
		logic [15:0] rate;
		logic [15:0] divider;
		wave_t       waveform;
	} acd_decode_t;

	// Character minus '0', wrapping in 16 bits.
	function automatic logic [15:0] digit16(input logic [7:0] c);
		return {8'h00, c} - {8'h00, CH_ZERO};
	endfunction

	// Multiply by ten modulo 2^16 as shift and add.
	function automatic logic [15:0] times10(input logic [15:0] x);
		return {x[12:0], 3'b000} + {x[14:0], 1'b0};
	endfunction

endpackage

@@ sv/ascii_command_decoder.sv @@
// Top level of the ASCII command decoder: input register, decode and held settings.
// One 8-character command word per item goes in; one result item comes out per word,
// held first in the input register and then in the result register, giving the command
// found in that word and all held settings (channel, sample rate, divider, waveform,
// latest command) after the update. A new word is accepted every cycle: the word sits
// in an input register, a single combinational decode feeds the held-setting registers
// and the result register, and the input side keeps taking items while the result
// register has room or is being drained in the same cycle.
`include "ascii_command_decoder_macros.svh"

module ascii_command_decoder import acd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// byte_0 [7:0], byte_1 [15:8], ... byte_7 [63:56]
	input  logic [WORD_W-1:0] s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// new_command [3:0], held_command [7:4], channel_out [15:8], rate_out [31:16],
	// divider_out [47:32], waveform_out [49:48], zero [55:50]
	output logic [OUT_W-1:0]  m_tdata
);

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              space;
	logic              advance;
	acd_decode_t       dec;

	assign advance  = valid_s1 && space;
	assign s_tready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) word_s1 <= s_tdata;
	end

	acd_parse u_parse (
		.word (word_s1),
		.dec  (dec)
	);

	acd_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.dec      (dec),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// a recognised command is also the held command
	`ACD_ASSERT_NOW(a_held_follows_new, m_tvalid && m_tdata[3:0] != CMD_NONE, m_tdata[7:4] == m_tdata[3:0])
	`ACD_ASSERT_NOW(a_wave_code, m_tvalid, m_tdata[49:48] != 2'd3 && m_tdata[55:50] == 6'd0)
	// hold the word in stage one while the result stage is stalled
	`ACD_ASSERT_NEXT(a_s1_holds, valid_s1 && m_tvalid && !m_tready, valid_s1 && $stable(word_s1))

endmodule

@@ sv/acd_parse.sv @@
// Combinational decode of one registered 8-character command word.
module acd_parse import acd_pkg::*; (
	input  logic [WORD_W-1:0] word,
	output acd_decode_t       dec
);

	logic [7:0]  b [8];
	logic [15:0] r2, r3, r4;
	logic [15:0] d1, d2, d3;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			b[i] = word[8*i +: 8];
		end
	end

	// Running decimal values for the rate (from byte 2) and divider (from byte 5)
	assign r2 = times10(digit16(b[2])) + digit16(b[3]);
	assign r3 = times10(r2) + digit16(b[4]);
	assign r4 = times10(r3) + digit16(b[5]);
	assign d1 = digit16(b[5]);
	assign d2 = times10(d1) + digit16(b[6]);
	assign d3 = times10(d2) + digit16(b[7]);

	always_comb begin
		dec.found    = CMD_NONE;
		dec.channel  = b[2] - CH_ZERO;
		dec.rate     = r2;
		dec.divider  = d3;
		dec.waveform = WAVE_SINE;
		case (b[0])
			CH_M: begin
				if (b[1] == CH_ZERO) dec.found = CMD_STOP;
				else if (b[1] == CH_ONE) dec.found = CMD_START;
			end
			CH_I: begin
				if (b[1] == CH_COMMA && b[3] == CH_DOT) dec.found = CMD_INPUT;
			end
			CH_C: begin
				if (b[1] == CH_COMMA) begin
					if (b[4] == CH_DOT) begin
						dec.rate  = r2;
						dec.found = CMD_RATE;
					end else if (b[5] == CH_DOT) begin
						dec.rate  = r3;
						dec.found = CMD_RATE;
					end else if (b[6] == CH_DOT) begin
						dec.rate  = r4;
						dec.found = CMD_RATE;
					end
				end
			end
			CH_T: begin
				if (b[1] == CH_ONE) dec.found = CMD_TEST1;
				else if (b[1] == CH_TWO) dec.found = CMD_TEST2;
			end
			CH_P: begin
				if (b[1] == CH_ONE && b[2] == CH_COMMA && b[4] == CH_COMMA) begin
					dec.found = CMD_GEN_START;
					// stop the digit count at the first dot
					if (b[6] == CH_DOT) dec.divider = d1;
					else if (b[7] == CH_DOT) dec.divider = d2;
					else dec.divider = d3;
					case (b[3])
						CH_R:    dec.waveform = WAVE_RAMP;
						CH_Q:    dec.waveform = WAVE_SQUARE;
						default: dec.waveform = WAVE_SINE;
					endcase
				end else if (b[1] == CH_ZERO) begin
					dec.found = CMD_GEN_STOP;
				end
			end
			default: dec.found = CMD_NONE;
		endcase
	end

endmodule

@@ sv/acd_state.sv @@
// Held settings, their update and the registered result item.
module acd_state import acd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  acd_decode_t      dec,
	output logic             space,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	cmd_t        last_q, last_nxt;
	logic [7:0]  channel_q, channel_nxt;
	logic [15:0] rate_q, rate_nxt;
	logic [15:0] divider_q, divider_nxt;
	wave_t       wave_q, wave_nxt;
	logic        valid_s2;
	logic [OUT_W-1:0] data_s2;

	assign space    = !valid_s2 || m_tready;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	always_comb begin
		last_nxt    = last_q;
		channel_nxt = channel_q;
		rate_nxt    = rate_q;
		divider_nxt = divider_q;
		wave_nxt    = wave_q;
		if (dec.found != CMD_NONE) last_nxt = dec.found;
		case (dec.found)
			CMD_INPUT: channel_nxt = dec.channel;
			CMD_RATE:  rate_nxt = dec.rate;
			CMD_GEN_START: begin
				divider_nxt = dec.divider;
				wave_nxt    = dec.waveform;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= CMD_NONE;
			channel_q <= CHANNEL_RESET;
			rate_q    <= RATE_RESET;
			divider_q <= DIVIDER_RESET;
			wave_q    <= WAVE_SINE;
			valid_s2  <= 1'b0;
		end else begin
			if (load) begin
				last_q    <= last_nxt;
				channel_q <= channel_nxt;
				rate_q    <= rate_nxt;
				divider_q <= divider_nxt;
				wave_q    <= wave_nxt;
				valid_s2  <= 1'b1;
			end else if (m_tready) begin
				valid_s2  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= {6'b000000, wave_nxt, divider_nxt, rate_nxt, channel_nxt,
				last_nxt, dec.found};
		end
	end

endmodule

@@ test/ascii_command_decoder_test.sv @@
// Stream testbench for the ASCII command decoder: directed and random command words, checked in order.
module ascii_command_decoder_test import acd_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 600;
	localparam int IDLE_LIMIT   = 1000;
	localparam int TAIL_CYCLES  = 8;

	// Result item as it sits in m_tdata, most significant field first.
	typedef struct packed {
		logic [5:0]  pad;
		wave_t       waveform;
		logic [15:0] divider;
		logic [15:0] rate;
		logic [7:0]  channel;
		cmd_t        held;
		cmd_t        found;
	} decode_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [WORD_W-1:0] s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	// Words waiting to be sent, and results owed by the decoder.
	logic [WORD_W-1:0] pending_words[$];
	decode_result_t    expected_results[$];

	// Held settings as the decoder should hold them.
	cmd_t        held_cmd = CMD_NONE;
	logic [7:0]  held_channel = CHANNEL_RESET;
	logic [15:0] held_rate = RATE_RESET;
	logic [15:0] held_divider = DIVIDER_RESET;
	wave_t       held_wave = WAVE_SINE;

	int fail_count = 0;
	int words_accepted = 0;
	int results_checked = 0;
	int idle_cycles = 0;
	int cmd_seen [9];
	logic word_taken = 1'b0;

	// Sender and receiver pacing.
	int burst_left = 1;
	int gap_left = 0;
	int stall_mode = 0;
	int cycle_count = 0;

	ascii_command_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Decimal value of count characters from byte first on, each taken as character minus '0'.
	function automatic logic [15:0] decimal_value(input logic [63:0] word, input int first,
			input int count);
		logic [15:0] acc;
		acc = '0;
		for (int i = 0; i < count; i++)
			acc = acc * 16'd10 + ({8'h00, word[8*(first+i) +: 8]} - {8'h00, CH_ZERO});
		return acc;
	endfunction

	// Decode one word against the held settings, update them, and return the result item.
	function automatic decode_result_t decode_word(input logic [63:0] word);
		logic [7:0] c [8];
		cmd_t found;
		int digits;
		decode_result_t res;
		for (int i = 0; i < 8; i++)
			c[i] = word[8*i +: 8];
		found = CMD_NONE;
		case (c[0])
			CH_M: begin
				if (c[1] == CH_ZERO)
					found = CMD_STOP;
				else if (c[1] == CH_ONE)
					found = CMD_START;
			end
			CH_I: begin
				if (c[1] == CH_COMMA && c[3] == CH_DOT) begin
					held_channel = c[2] - CH_ZERO;
					found = CMD_INPUT;
				end
			end
			CH_C: begin
				if (c[1] == CH_COMMA) begin
					if (c[4] == CH_DOT)
						digits = 2;
					else if (c[5] == CH_DOT)
						digits = 3;
					else if (c[6] == CH_DOT)
						digits = 4;
					else
						digits = 0;
					// no terminator within four digits: the word is not taken as a rate command
					if (digits != 0) begin
						held_rate = decimal_value(word, 2, digits);
						found = CMD_RATE;
					end
				end
			end
			CH_T: begin
				if (c[1] == CH_ONE)
					found = CMD_TEST1;
				else if (c[1] == CH_TWO)
					found = CMD_TEST2;
			end
			CH_P: begin
				if (c[1] == CH_ONE && c[2] == CH_COMMA && c[4] == CH_COMMA) begin
					if (c[6] == CH_DOT)
						digits = 1;
					else if (c[7] == CH_DOT)
						digits = 2;
					else
						digits = 3;
					held_divider = decimal_value(word, 5, digits);
					if (c[3] == CH_R)
						held_wave = WAVE_RAMP;
					else if (c[3] == CH_Q)
						held_wave = WAVE_SQUARE;
					else
						held_wave = WAVE_SINE;
					found = CMD_GEN_START;
				end else if (c[1] == CH_ZERO) begin
					found = CMD_GEN_STOP;
				end
			end
			default: ;
		endcase
		if (found != CMD_NONE)
			held_cmd = found;
		cmd_seen[found]++;
		res.pad = '0;
		res.waveform = held_wave;
		res.divider = held_divider;
		res.rate = held_rate;
		res.channel = held_channel;
		res.held = held_cmd;
		res.found = found;
		return res;
	endfunction

	// Word from text, padded with fill.
	function automatic logic [63:0] word_of(input string text, input logic [7:0] fill);
		logic [63:0] w;
		for (int i = 0; i < 8; i++)
			w[8*i +: 8] = (i < text.len()) ? text[i] : fill;
		return w;
	endfunction

	function automatic logic [7:0] digit_char();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Command word of a random kind, sometimes malformed, with random trailing characters.
	function automatic logic [63:0] random_command();
		logic [63:0] w;
		int kind;
		int n;
		w = {$urandom, $urandom};
		kind = $urandom_range(0, 7);
		if (kind == 6)
			kind = 2;
		if (kind == 7)
			kind = 4;
		case (kind)
			0: begin
				w[7:0] = CH_M;
				n = $urandom_range(0, 4);
				w[15:8] = (n < 2) ? CH_ZERO : (n < 4) ? CH_ONE : 8'($urandom_range(0, 255));
			end
			1: begin
				w[7:0] = CH_I;
				w[15:8] = CH_COMMA;
				w[23:16] = digit_char();
				if ($urandom_range(0, 9) != 0)
					w[31:24] = CH_DOT;
			end
			2: begin
				w[7:0] = CH_C;
				w[15:8] = CH_COMMA;
				n = $urandom_range(2, 5);
				for (int i = 0; i < n; i++)
					w[8*(2+i) +: 8] = digit_char();
				if (n <= 4)
					w[8*(2+n) +: 8] = CH_DOT;
			end
			3: begin
				w[7:0] = CH_T;
				n = $urandom_range(0, 4);
				w[15:8] = (n < 2) ? CH_ONE : (n < 4) ? CH_TWO : 8'($urandom_range(0, 255));
			end
			4: begin
				w[7:0] = CH_P;
				w[15:8] = CH_ONE;
				w[23:16] = CH_COMMA;
				n = $urandom_range(0, 3);
				w[31:24] = (n == 0) ? CH_S : (n == 1) ? CH_R : (n == 2) ? CH_Q :
					8'($urandom_range(0, 255));
				w[39:32] = CH_COMMA;
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					w[8*(5+i) +: 8] = digit_char();
				if (n < 3)
					w[8*(5+n) +: 8] = CH_DOT;
			end
			default: begin
				w[7:0] = CH_P;
				w[15:8] = CH_ZERO;
			end
		endcase
		return w;
	endfunction

	initial begin
		logic [63:0] w;
		int k;
		foreach (cmd_seen[i])
			cmd_seen[i] = 0;

		pending_words.push_back(word_of("M0", CH_DOT));
		pending_words.push_back(word_of("M1", 8'h00));
		pending_words.push_back(word_of("M2", 8'hFF));
		pending_words.push_back(word_of("I,5.", 8'h20));
		w = word_of("I,x.", 8'hFF);
		w[23:16] = 8'h00;
		pending_words.push_back(w);
		pending_words.push_back(word_of("I,5x", CH_DOT));
		pending_words.push_back(word_of("C,12.", 8'h00));
		pending_words.push_back(word_of("C,123.", 8'hFF));
		pending_words.push_back(word_of("C,9999.", 8'h00));
		pending_words.push_back(word_of("C,12345", CH_DOT));
		w = word_of("C,xxxx.", 8'hFF);
		w[47:16] = 32'hFFFF_FFFF;
		pending_words.push_back(w);
		pending_words.push_back(word_of("T1", 8'h00));
		pending_words.push_back(word_of("T2", 8'hFF));
		pending_words.push_back(word_of("T3", 8'h00));
		pending_words.push_back(word_of("P1,S,5.", 8'h00));
		pending_words.push_back(word_of("P1,R,12.", 8'h00));
		pending_words.push_back(word_of("P1,Q,999", 8'h00));
		pending_words.push_back(word_of("P1,Z,7.", 8'hFF));
		pending_words.push_back(word_of("P0", 8'hFF));
		pending_words.push_back(word_of("P1;S,5.", 8'h00));
		w = word_of("P1,Q,", 8'h00);
		pending_words.push_back(w);
		w = word_of("P1,R,", 8'hFF);
		pending_words.push_back(w);
		pending_words.push_back('0);
		pending_words.push_back('1);

		// mostly random commands; the rest noise or a command with one character broken
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			k = $urandom_range(0, 7);
			if (k < 6) begin
				w = random_command();
			end else if (k == 6) begin
				w = {$urandom, $urandom};
			end else begin
				w = random_command();
				w[8*$urandom_range(0, 7) +: 8] = 8'($urandom_range(0, 255));
			end
			pending_words.push_back(w);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d words, %0d results; stop %0d, start %0d, input %0d, rate %0d",
			words_accepted, results_checked, cmd_seen[CMD_STOP], cmd_seen[CMD_START],
			cmd_seen[CMD_INPUT], cmd_seen[CMD_RATE]);
		$display("test1 %0d, test2 %0d, gen start %0d, gen stop %0d, unrecognised %0d",
			cmd_seen[CMD_TEST1], cmd_seen[CMD_TEST2], cmd_seen[CMD_GEN_START],
			cmd_seen[CMD_GEN_STOP], cmd_seen[CMD_NONE]);
		if (fail_count == 0)
			$display("ascii_command_decoder_test passed");
		else
			$display("ascii_command_decoder_test failed");
		$finish;
	end

	// Driver and receiver pacing, both at the falling edge.
	always @(negedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 128 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (cycle_count % 5) < 2;
			default: m_tready <= (cycle_count % 16) == 0;
		endcase

		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !word_taken) begin
			// hold the item until it is taken
		end else if (gap_left != 0) begin
			s_tvalid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_words.size() != 0) begin
			s_tvalid <= 1'b1;
			s_tdata <= pending_words[0];
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 24);
				gap_left <= ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 12);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Monitor: check results, predict accepted words, watch for a stuck stream.
	always @(posedge clk) begin
		decode_result_t got;
		decode_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_results.size() == 0) begin
					$error("result item with no word waiting for it");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("new_command", want.found, got.found);
					check_field("held_command", want.held, got.held);
					check_field("channel_out", want.channel, got.channel);
					check_field("rate_out", want.rate, got.rate);
					check_field("divider_out", want.divider, got.divider);
					check_field("waveform_out", want.waveform, got.waveform);
					check_field("zero", want.pad, got.pad);
					results_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(decode_word(pending_words.pop_front()));
				words_accepted++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("ascii_command_decoder_test failed");
				$finish;
			end
		end
		word_taken <= s_tvalid && s_tready;
	end

endmodule
